// ===== hdl/ltc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_pkg: shared definitions for the LRU tag cache
// Sizes, command codes, queue item types and helper functions used by the
// request front end, the directory engine and the top level.
// ----------------------------------------------------------------------------
package ltc_pkg;

   localparam int SLOTS      = 16;
   localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RANK_W     = IDX_W;
   localparam int OCC_W      = $clog2(SLOTS + 1);
   localparam int CAP_W      = 5;
   localparam int CMP_W      = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int CMD_W      = 3;
   localparam int FONT_W     = 8;
   localparam int SIZE_W     = 16;
   localparam int TAG_W      = 32;
   localparam int KEY_W      = FONT_W + SIZE_W + TAG_W;
   localparam int SLOT_OUT_W = 4;
   localparam int DATA_W     = 32;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_ACCESS     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PROBE      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INVAL_KEY  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INVAL_FONT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd5;

   typedef enum logic [2:0] {
      OP_ACCESS,
      OP_PROBE,
      OP_INVAL_KEY,
      OP_INVAL_FONT,
      OP_CLEAR,
      OP_TICK,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [FONT_W-1:0]   font_id;
      logic [SIZE_W-1:0]   size_code;
      logic [TAG_W-1:0]    text_tag;
   } cmd_item_type;

   typedef struct packed {
      logic         valid;
      cmd_item_type item;
   } queue_head_type;

   typedef struct packed {
      logic [QCNT_W-1:0] q_count;
   } front_status_type;

   typedef struct packed {
      logic             pop;
      logic [OCC_W-1:0] occupancy;
   } back_status_type;

   // Index of the set bit of a one-hot vector (zero when none is set).
   function automatic logic [IDX_W-1:0] onehot_index(input logic [SLOTS-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (v[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // Lowest index whose bit is clear.
   function automatic logic [IDX_W-1:0] first_zero(input logic [SLOTS-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!v[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // Low four bits of a slot index, zero extended for small directories.
   function automatic logic [SLOT_OUT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_OUT_W-1:0] wide;
      wide = {{SLOT_OUT_W{1'b0}}, idx};
      return wide[SLOT_OUT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ltc_intf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_intf: request and response channels of the LRU tag cache
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ltc_req_if;
   import ltc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [FONT_W-1:0] font_id;
   logic [SIZE_W-1:0] size_code;
   logic [TAG_W-1:0]  text_tag;

   modport source (output valid, output command, output font_id, output size_code,
                   output text_tag, input ready);
   modport sink (input valid, input command, input font_id, input size_code,
                 input text_tag, output ready);
endinterface

interface ltc_rsp_if;
   import ltc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [SLOT_OUT_W-1:0] slot;
   logic                  evicted;
   logic [DATA_W-1:0]     access_frame;
   logic [DATA_W-1:0]     hit_total;
   logic [DATA_W-1:0]     miss_total;

   modport source (output valid, output hit, output slot, output evicted,
                   output access_frame, output hit_total, output miss_total,
                   input ready);
   modport sink (input valid, input hit, input slot, input evicted,
                 input access_frame, input hit_total, input miss_total,
                 output ready);
endinterface
`default_nettype wire

// ===== hdl/ltc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_front: request front end
// Accepts requests, decodes the command into an operation and holds the
// decoded requests in a short queue for the directory engine.
// ----------------------------------------------------------------------------
module ltc_front (
   input  wire                     clock,
   input  wire                     reset,
   ltc_req_if.sink                 req_if,
   input  wire                     q_pop,
   output ltc_pkg::queue_head_type q_head,
   output ltc_pkg::front_status_type fe_status
);
   import ltc_pkg::*;

   cmd_item_type      queue_ff [QDEPTH];
   cmd_item_type      queue_in [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   cmd_item_type      decoded;
   logic              push;
   logic              pop;

   always_comb begin
      unique case (req_if.command)
         CMD_ACCESS:     decoded.op = OP_ACCESS;
         CMD_PROBE:      decoded.op = OP_PROBE;
         CMD_INVAL_KEY:  decoded.op = OP_INVAL_KEY;
         CMD_INVAL_FONT: decoded.op = OP_INVAL_FONT;
         CMD_CLEAR:      decoded.op = OP_CLEAR;
         CMD_TICK:       decoded.op = OP_TICK;
         default:        decoded.op = OP_NOP;
      endcase
      decoded.font_id   = req_if.font_id;
      decoded.size_code = req_if.size_code;
      decoded.text_tag  = req_if.text_tag;
   end

   assign req_if.ready = (count_ff != QCNT_W'(QDEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign pop          = q_pop && (count_ff != '0);

   always_comb begin
      queue_in  = queue_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         queue_in[wr_ptr_ff] = decoded;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      queue_ff <= queue_in;
   end

   assign q_head.valid      = (count_ff != '0);
   assign q_head.item       = queue_ff[rd_ptr_ff];
   assign fe_status.q_count = count_ff;

endmodule
`default_nettype wire

// ===== hdl/ltc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_back: directory engine
// Holds the entries, age ranks, frames and counters. A request is looked up,
// then carried out once the registered response stage can take its result;
// a font invalidation then walks all slots, one per cycle.
// ----------------------------------------------------------------------------
module ltc_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_wr_en,
   input  wire [ltc_pkg::CAP_W-1:0]   csr_wr_data,
   input  ltc_pkg::queue_head_type    q_head,
   output logic                       q_pop,
   ltc_rsp_if.source                  rsp_if,
   output ltc_pkg::back_status_type   be_status
);
   import ltc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_FONT} state_type;

   state_type             state_ff, state_in;
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic [KEY_W-1:0]      key_ff [SLOTS];
   logic [KEY_W-1:0]      key_in [SLOTS];
   logic [RANK_W-1:0]     rank_ff [SLOTS];
   logic [RANK_W-1:0]     rank_in [SLOTS];
   logic [DATA_W-1:0]     frame_ff [SLOTS];
   logic [DATA_W-1:0]     frame_in [SLOTS];
   logic [DATA_W-1:0]     frame_cnt_ff, frame_cnt_in;
   logic [DATA_W-1:0]     hit_cnt_ff, hit_cnt_in;
   logic [DATA_W-1:0]     miss_cnt_ff, miss_cnt_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   cmd_item_type          cur_ff, cur_in;
   logic [SLOTS-1:0]      match_ff, match_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic [DATA_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic [DATA_W-1:0]     rsp_hit_total_ff, rsp_hit_total_in;
   logic [DATA_W-1:0]     rsp_miss_total_ff, rsp_miss_total_in;

   logic [KEY_W-1:0]      head_key;
   logic [KEY_W-1:0]      cur_key;
   logic                  out_free;
   logic                  hit_any;
   logic [IDX_W-1:0]      hit_idx;
   logic [RANK_W-1:0]     hit_rank;
   logic [SLOTS-1:0]      evict_vec;
   logic                  evict_need;
   logic                  do_evict;
   logic [IDX_W-1:0]      fill_idx;
   logic                  drop_en;
   logic [IDX_W-1:0]      drop_sel;
   logic [RANK_W-1:0]     drop_rank;
   logic                  rsp_load;

   assign head_key = {q_head.item.font_id, q_head.item.size_code, q_head.item.text_tag};
   assign cur_key  = {cur_ff.font_id, cur_ff.size_code, cur_ff.text_tag};
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign hit_any  = |match_ff;
   assign hit_idx  = onehot_index(match_ff);
   assign hit_rank = rank_ff[hit_idx];

   // The least recent entry holds rank occupancy-1. Capacity zero acts as one,
   // and a full directory always evicts even when capacity is set higher.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         evict_vec[i] = valid_ff[i] && (rank_ff[i] == RANK_W'(occ_ff - 1'b1));
      end
   end
   assign evict_need = (occ_ff != '0) &&
                       ((CMP_W'(occ_ff) >= CMP_W'(cap_ff)) || (occ_ff == OCC_W'(SLOTS)));
   assign do_evict   = evict_need && (|evict_vec);
   assign fill_idx   = do_evict ? onehot_index(evict_vec) : first_zero(valid_ff);
   assign drop_rank  = rank_ff[drop_sel];

   always_comb begin
      state_in          = state_ff;
      valid_in          = valid_ff;
      key_in            = key_ff;
      rank_in           = rank_ff;
      frame_in          = frame_ff;
      frame_cnt_in      = frame_cnt_ff;
      hit_cnt_in        = hit_cnt_ff;
      miss_cnt_in       = miss_cnt_ff;
      occ_in            = occ_ff;
      cap_in            = csr_wr_en ? csr_wr_data : cap_ff;
      cur_in            = cur_ff;
      match_in          = match_ff;
      scan_in           = scan_ff;
      q_pop             = 1'b0;
      drop_en           = 1'b0;
      drop_sel          = hit_idx;
      rsp_load          = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_if.ready;
      rsp_hit_in        = rsp_hit_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_evicted_in    = rsp_evicted_ff;
      rsp_frame_in      = rsp_frame_ff;
      rsp_hit_total_in  = rsp_hit_total_ff;
      rsp_miss_total_in = rsp_miss_total_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop  = 1'b1;
               cur_in = q_head.item;
               for (int i = 0; i < SLOTS; i++) begin
                  match_in[i] = valid_ff[i] && (key_ff[i] == head_key);
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_hit_in     = 1'b0;
               rsp_slot_in    = '0;
               rsp_evicted_in = 1'b0;
               rsp_frame_in   = '0;
               state_in       = ST_IDLE;
               case (cur_ff.op)
                  OP_ACCESS: begin
                     rsp_frame_in = frame_cnt_ff;
                     if (hit_any) begin
                        rsp_hit_in  = 1'b1;
                        rsp_slot_in = to_slot(hit_idx);
                        hit_cnt_in  = hit_cnt_ff + 1'b1;
                        for (int i = 0; i < SLOTS; i++) begin
                           if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                              rank_in[i] = rank_ff[i] + 1'b1;
                           end
                        end
                        rank_in[hit_idx]  = '0;
                        frame_in[hit_idx] = frame_cnt_ff;
                     end else begin
                        rsp_slot_in    = to_slot(fill_idx);
                        rsp_evicted_in = do_evict;
                        miss_cnt_in    = miss_cnt_ff + 1'b1;
                        // Every other live entry ages by one; the evicted one
                        // is the slot being refilled.
                        for (int i = 0; i < SLOTS; i++) begin
                           if (IDX_W'(i) == fill_idx) begin
                              valid_in[i] = 1'b1;
                              key_in[i]   = cur_key;
                              rank_in[i]  = '0;
                              frame_in[i] = frame_cnt_ff;
                           end else if (valid_ff[i]) begin
                              rank_in[i] = rank_ff[i] + 1'b1;
                           end
                        end
                        if (!do_evict) begin
                           occ_in = occ_ff + 1'b1;
                        end
                     end
                  end
                  OP_PROBE: begin
                     if (hit_any) begin
                        rsp_hit_in   = 1'b1;
                        rsp_frame_in = frame_ff[hit_idx];
                     end
                  end
                  OP_INVAL_KEY: begin
                     if (hit_any) begin
                        rsp_hit_in = 1'b1;
                        drop_en    = 1'b1;
                     end
                  end
                  OP_INVAL_FONT: begin
                     scan_in  = '0;
                     state_in = ST_FONT;
                  end
                  OP_CLEAR: begin
                     valid_in = '0;
                     occ_in   = '0;
                  end
                  OP_TICK: begin
                     frame_cnt_in = frame_cnt_ff + 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FONT: begin
            drop_sel = scan_ff;
            drop_en  = valid_ff[scan_ff] &&
                       (key_ff[scan_ff][KEY_W-1 -: FONT_W] == cur_ff.font_id);
            scan_in  = scan_ff + 1'b1;
            if (scan_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Dropping an entry closes the gap it leaves in the age ranks.
      if (drop_en) begin
         valid_in[drop_sel] = 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            if (valid_ff[i] && (rank_ff[i] > drop_rank)) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
         end
         if (occ_ff != '0) begin
            occ_in = occ_ff - 1'b1;
         end
      end

      if (rsp_load) begin
         rsp_valid_in      = 1'b1;
         rsp_hit_total_in  = hit_cnt_in;
         rsp_miss_total_in = miss_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         frame_cnt_ff <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         frame_cnt_ff <= frame_cnt_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff            <= key_in;
      rank_ff           <= rank_in;
      frame_ff          <= frame_in;
      cur_ff            <= cur_in;
      match_ff          <= match_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_evicted_ff    <= rsp_evicted_in;
      rsp_frame_ff      <= rsp_frame_in;
      rsp_hit_total_ff  <= rsp_hit_total_in;
      rsp_miss_total_ff <= rsp_miss_total_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hit          = rsp_hit_ff;
   assign rsp_if.slot         = rsp_slot_ff;
   assign rsp_if.evicted      = rsp_evicted_ff;
   assign rsp_if.access_frame = rsp_frame_ff;
   assign rsp_if.hit_total    = rsp_hit_total_ff;
   assign rsp_if.miss_total   = rsp_miss_total_ff;

   assign be_status.pop       = q_pop;
   assign be_status.occupancy = occ_ff;

endmodule
`default_nettype wire

// ===== hdl/lru_tag_cache_with_invalidate_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_tag_cache_with_invalidate_top: fully associative LRU tag directory
// Requests enter on req_if (access, probe, invalidate key, invalidate font,
// clear, frame tick); each request produces exactly one response on rsp_if
// carrying hit, slot, eviction flag, frame and the running hit/miss totals.
// csr_wr_en/csr_wr_data write the capacity register; write it only while
// no request is outstanding.
// A request is queued (two entries) when it is accepted, then popped by the
// engine and looked up against all slots into a registered match vector,
// and carried out once the response output register is free.
// The engine takes a new request only once it has carried out the last; an
// invalidate-font request also walks every slot before the next is taken.
// When the receiver stalls, the response is held in its output register,
// the engine waits on the next response and the queue absorbs two more
// requests before req_if.ready drops.
// Reset empties the directory, zeros the frame and hit/miss counters and
// sets capacity to 16; the block accepts requests on the next cycle.
// ----------------------------------------------------------------------------
module lru_tag_cache_with_invalidate_top (
   input  wire                      clock,
   input  wire                      reset,
   ltc_req_if.sink                  req_if,
   ltc_rsp_if.source                rsp_if,
   input  wire                      csr_wr_en,
   input  wire [ltc_pkg::CAP_W-1:0] csr_wr_data
);
   import ltc_pkg::*;

   queue_head_type   q_head;
   logic             q_pop;
   front_status_type fe_status;
   back_status_type  be_status;

   ltc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .fe_status (fe_status)
   );

   ltc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_if      (rsp_if),
      .be_status   (be_status)
   );

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fe_status.q_count <= QCNT_W'(QDEPTH))
      else $error("request queue holds more than its depth");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      be_status.occupancy <= OCC_W'(SLOTS))
      else $error("occupancy exceeds the number of slots");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      be_status.pop |-> q_head.valid)
      else $error("engine took a request from an empty queue");

   a_pop_spacing: assert property (@(posedge clock) disable iff (reset)
      be_status.pop |=> !be_status.pop)
      else $error("engine took two requests in consecutive cycles");
`endif

endmodule
`default_nettype wire
